[rtl/adaptive_release_output_buffer_top_defines.svh]
// Assertion macros shared by the adaptive release output buffer RTL
`ifndef ADAPTIVE_RELEASE_OUTPUT_BUFFER_TOP_DEFINES_SVH
`define ADAPTIVE_RELEASE_OUTPUT_BUFFER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define AROB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset
`define AROB_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define AROB_ASSERT(label, clk, rst_n, prop)
`define AROB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/arob_pkg.sv]
// Types and constants of the adaptive release output buffer
`timescale 1ns / 1ps
package arob_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned OCC_W      = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [INTERVAL_W-1:0] INITIAL_INTERVAL_RESET = 16'd1;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET     = 16'd160;
  localparam logic [INTERVAL_W-1:0] TICKS_RESET            = 16'd1;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_INITIAL_INTERVAL = 1'b0,
    REG_MAX_INTERVAL     = 1'b1
  } reg_idx_e;

  // Configuration seen by the control path
  typedef struct packed {
    logic                  init_load;
    logic [INTERVAL_W-1:0] init_value;
    logic [INTERVAL_W-1:0] max_interval;
  } cfg_t;

  function automatic logic [INTERVAL_W-1:0] at_least_one(input logic [INTERVAL_W-1:0] v);
    return (v == '0) ? INTERVAL_W'(1) : v;
  endfunction

endpackage

[rtl/arob_in_if.sv]
// Input channel: push or tick items
`timescale 1ns / 1ps
interface arob_in_if
  import arob_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

[rtl/arob_out_if.sv]
// Output channel: released words
`timescale 1ns / 1ps
interface arob_out_if
  import arob_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] released_value;
  logic [INTERVAL_W-1:0]     interval_now;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output released_value, output interval_now,
                  output occupancy, input ready);
  modport sink   (input valid, input released_value, input interval_now,
                  input occupancy, output ready);
endinterface

[rtl/arob_regs.sv]
// APB configuration registers of the adaptive release output buffer
`timescale 1ns / 1ps
module arob_regs
  import arob_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [INTERVAL_W-1:0] initial_interval_q, initial_interval_d;
  logic [INTERVAL_W-1:0] max_interval_q, max_interval_d;
  logic                  wr_en;
  reg_idx_e              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    initial_interval_d = initial_interval_q;
    max_interval_d     = max_interval_q;
    cfg_o.init_load    = 1'b0;
    cfg_o.init_value   = pwdata[INTERVAL_W-1:0];
    prdata             = '0;
    unique case (reg_idx)
      REG_INITIAL_INTERVAL: begin
        prdata = APB_DATA_W'(initial_interval_q);
        if (wr_en) begin
          initial_interval_d = pwdata[INTERVAL_W-1:0];
          cfg_o.init_load    = 1'b1;
        end
      end
      REG_MAX_INTERVAL: begin
        prdata = APB_DATA_W'(max_interval_q);
        if (wr_en) begin
          max_interval_d = pwdata[INTERVAL_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
    cfg_o.max_interval = max_interval_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_interval_q <= INITIAL_INTERVAL_RESET;
      max_interval_q     <= MAX_INTERVAL_RESET;
    end else begin
      initial_interval_q <= initial_interval_d;
      max_interval_q     <= max_interval_d;
    end
  end

endmodule

[rtl/arob_mem.sv]
// Word storage of the release buffer, one write and one registered read port
`timescale 1ns / 1ps
module arob_mem
  import arob_pkg::*;
#(
  parameter int unsigned BufferDepth = 8,
  localparam int unsigned PtrW = $clog2(BufferDepth)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [PtrW-1:0]           wr_addr_i,
  input  logic signed [VALUE_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [PtrW-1:0]           rd_addr_i,
  output logic signed [VALUE_W-1:0] rd_data_o
);

  logic signed [VALUE_W-1:0] mem_q [BufferDepth];
  logic signed [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/arob_ctrl.sv]
// Pointers, release timer, interval adaptation and result register
`timescale 1ns / 1ps
`include "adaptive_release_output_buffer_top_defines.svh"
module arob_ctrl
  import arob_pkg::*;
#(
  parameter int unsigned BufferDepth = 8,
  localparam int unsigned PtrW = $clog2(BufferDepth),
  localparam int unsigned CntW = $clog2(BufferDepth + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  input  logic                  cmd_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [INTERVAL_W-1:0] interval_now_o,
  output logic [OCC_W-1:0]      occupancy_o,
  output logic                  wr_en_o,
  output logic [PtrW-1:0]       wr_addr_o,
  output logic                  rd_en_o,
  output logic [PtrW-1:0]       rd_addr_o
);

  logic [PtrW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [INTERVAL_W-1:0] ticks_q, ticks_d;
  logic                  out_valid_q, out_valid_d;
  logic [INTERVAL_W-1:0] interval_now_q, interval_now_d;
  logic [OCC_W-1:0]      occupancy_q, occupancy_d;

  logic                  accept, push, tick, pop, full, expire;
  logic [CntW:0]         tail_sum;
  logic [PtrW-1:0]       tail, head_inc;
  logic [INTERVAL_W:0]   doubled;
  logic [INTERVAL_W-1:0] cap, halved;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && (cmd_i == CMD_PUSH);
  assign tick       = accept && (cmd_i == CMD_TICK);
  assign full       = (count_q == CntW'(BufferDepth));
  assign expire     = (ticks_q <= INTERVAL_W'(1));
  assign pop        = tick && expire && (count_q != '0);

  assign tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
  assign tail     = (tail_sum >= (CntW + 1)'(BufferDepth))
                    ? PtrW'(tail_sum - (CntW + 1)'(BufferDepth)) : PtrW'(tail_sum);
  assign head_inc = (head_q == PtrW'(BufferDepth - 1)) ? '0 : head_q + PtrW'(1);

  assign cap     = at_least_one(cfg_i.max_interval);
  assign doubled = {interval_q, 1'b0};
  assign halved  = at_least_one(interval_q >> 1);

  // Storage accesses: write at tail, or over the head when full
  assign wr_en_o   = push;
  assign wr_addr_o = full ? head_q : tail;
  assign rd_en_o   = pop;
  assign rd_addr_o = head_q;

  always_comb begin
    head_d         = head_q;
    count_d        = count_q;
    interval_d     = interval_q;
    ticks_d        = ticks_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    interval_now_d = interval_now_q;
    occupancy_d    = occupancy_q;
    priority if (cfg_i.init_load) begin
      interval_d = at_least_one(cfg_i.init_value);
      ticks_d    = at_least_one(cfg_i.init_value);
    end else if (push) begin
      if (full) begin
        head_d = head_inc;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (tick && !expire) begin
      ticks_d = ticks_q - INTERVAL_W'(1);
    end else if (tick && (count_q == '0)) begin
      // Nothing to release: back off
      interval_d = (doubled > (INTERVAL_W + 1)'(cap)) ? cap : doubled[INTERVAL_W-1:0];
      ticks_d    = interval_d;
    end else if (pop) begin
      head_d  = head_inc;
      count_d = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        interval_d = halved;
      end
      ticks_d        = interval_d;
      out_valid_d    = 1'b1;
      interval_now_d = interval_d;
      occupancy_d    = OCC_W'(count_d);
    end else begin
      // No transfer: hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      interval_q  <= INITIAL_INTERVAL_RESET;
      ticks_q     <= TICKS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      interval_q  <= interval_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    interval_now_q <= interval_now_d;
    occupancy_q    <= occupancy_d;
  end

  assign out_valid_o    = out_valid_q;
  assign interval_now_o = interval_now_q;
  assign occupancy_o    = occupancy_q;

  `AROB_ASSERT_NEVER(a_count_overflow, clk_i, rst_ni, count_q > CntW'(BufferDepth))
  `AROB_ASSERT_NEVER(a_interval_zero, clk_i, rst_ni, interval_q == '0)
  `AROB_ASSERT_NEVER(a_ticks_zero, clk_i, rst_ni, ticks_q == '0)
  `AROB_ASSERT(a_full_push_holds, clk_i, rst_ni, push && full && !cfg_i.init_load |=> full)
  `AROB_ASSERT(a_pop_shows_result, clk_i, rst_ni, pop && !cfg_i.init_load |=> out_valid_q)

endmodule

[rtl/adaptive_release_output_buffer_top.sv]
// Adaptive release output buffer: usage
//   in_i  : push (cmd 0, value) or tick (cmd 1) items, valid/ready transfer.
//   out_o : one released word per expiring tick that finds the buffer non-empty,
//           with the interval after the release and the occupancy left.
//   APB   : reg 0 at 0x0 initial_interval (writing it reloads interval and timer),
//           reg 1 at 0x4 max_interval. pready is always high.
// A releasing tick shows its result in the cycle after its transfer.
// Throughput: one item per cycle but for a receiver stall; every item is settled
//   in one pass of the pointer/timer logic; the word comes from the registered read.
// A push on a full buffer overwrites the oldest word. An empty expiry doubles
//   the interval up to max_interval; a pop that empties the buffer halves it.
// Reset: buffer empty, interval 1, timer 1, max_interval 160.
// Receiver stall: the result register holds; in_i.ready drops only while a
//   result waits and out_o.ready is low, so one output register parts the sides.
`timescale 1ns / 1ps
module adaptive_release_output_buffer_top
  import arob_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  arob_in_if.sink               in_i,
  arob_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PtrW = $clog2(BUFFER_DEPTH);

  cfg_t            cfg;
  logic            wr_en, rd_en;
  logic [PtrW-1:0] wr_addr, rd_addr;

  arob_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  arob_ctrl #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .cmd_i         (in_i.cmd),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .interval_now_o(out_o.interval_now),
    .occupancy_o   (out_o.occupancy),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr)
  );

  arob_mem #(
    .BufferDepth(BUFFER_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_i.value),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(out_o.released_value)
  );

endmodule
